>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files; all sample on clock and are
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SGC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SGC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/sgc_pkg.sv
// ---------------------------------------------------------------------------
// sgc_pkg
// Shared constants and types of the clamped Sobel gradient block.
// ---------------------------------------------------------------------------
package sgc_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = ADDR_W + 1;
   localparam int ROW_W     = 12;
   localparam int FW_W      = 11;
   localparam int PIX_W     = 8;
   localparam int GRAD_W    = 11;
   localparam int MAG_W     = 8;
   localparam int SQ_W      = 2 * GRAD_W;
   localparam int ROOT_W    = 16;
   localparam int STEP_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 12;
   localparam int RSP_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] bot;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] top;
   } col_type;

   typedef struct packed {
      col_type left;
      col_type center;
      col_type right;
      logic    eor;
      logic    eof;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PIX, ST_FL0, ST_FL1, ST_FL2, ST_ISSUE
   } ctl_state_type;

   typedef enum logic [2:0] {
      G_IDLE, G_SQR, G_SUM, G_ROOT, G_DONE
   } grad_state_type;

endpackage

>>> rtl/sgc_ram.sv
// ---------------------------------------------------------------------------
// sgc_ram
// Single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module sgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sgc_grad.sv
// ---------------------------------------------------------------------------
// sgc_grad
// Sobel derivatives of one 3x3 window and the saturated integer square
// root of their squared sum, one root bit per cycle, with an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sgc_grad (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  sgc_pkg::job_type                    job,
   output logic                                ready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // grad_x [10:0], grad_y [21:11], magnitude [29:22], zero [31:30]
   output logic [sgc_pkg::RSP_DAT_W-1:0]       rsp_tdata,
   output logic                                rsp_tlast,
   // end_of_frame [0]
   output logic [0:0]                          rsp_tuser
);
   import sgc_pkg::*;

   grad_state_type state_ff, state_in;
   logic signed [GRAD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]   sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [ROOT_W-1:0] val_ff, val_in;
   logic              sat_ff, sat_in;
   logic [MAG_W-1:0]  root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              eor_ff, eor_in, eof_ff, eof_in;
   logic              ov_ff, ov_in;
   logic signed [GRAD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [MAG_W-1:0]  om_ff, om_in;
   logic              oeor_ff, oeor_in, oeof_ff, oeof_in;
   logic              load;

   function automatic logic [PIX_W+1:0] wsum(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
      return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         G_IDLE:  if (start) state_in = G_SQR;
         G_SQR:   state_in = G_SUM;
         G_SUM:   state_in = G_ROOT;
         G_ROOT:  if (step_ff == '0) state_in = G_DONE;
         G_DONE:  if (!ov_ff || rsp_tready) state_in = G_IDLE;
         default: state_in = G_IDLE;
      endcase
   end

   always_comb begin
      ready = (state_ff == G_IDLE);
      load  = (state_ff == G_DONE) && (!ov_ff || rsp_tready);
   end

   always_comb begin
      logic signed [SQ_W-1:0] px, py;
      logic [SQ_W:0]          sum;
      logic [MAG_W-1:0]       bitv, t;
      logic [ROOT_W-1:0]      tt;
      dx_in = dx_ff;
      dy_in = dy_ff;
      eor_in = eor_ff;
      eof_in = eof_ff;
      if (state_ff == G_IDLE && start) begin
         dx_in = signed'({1'b0, wsum(job.right.top, job.right.mid, job.right.bot)})
               - signed'({1'b0, wsum(job.left.top, job.left.mid, job.left.bot)});
         dy_in = signed'({1'b0, wsum(job.left.bot, job.center.bot, job.right.bot)})
               - signed'({1'b0, wsum(job.left.top, job.center.top, job.right.top)});
         eor_in = job.eor;
         eof_in = job.eof;
      end
      px = dx_ff * dx_ff;
      py = dy_ff * dy_ff;
      sqx_in = (state_ff == G_SQR) ? unsigned'(px) : sqx_ff;
      sqy_in = (state_ff == G_SQR) ? unsigned'(py) : sqy_ff;
      sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      val_in = val_ff;
      sat_in = sat_ff;
      root_in = root_ff;
      step_in = step_ff;
      bitv = MAG_W'(1) << step_ff;
      t = root_ff | bitv;
      tt = ROOT_W'(t) * ROOT_W'(t);
      if (state_ff == G_SUM) begin
         val_in  = sum[ROOT_W-1:0];
         sat_in  = |sum[SQ_W:ROOT_W];
         root_in = '0;
         step_in = STEP_W'(MAG_W - 1);
      end else if (state_ff == G_ROOT) begin
         if (tt <= val_ff) root_in = t;
         step_in = step_ff - STEP_W'(1);
      end
      ox_in = load ? dx_ff : ox_ff;
      oy_in = load ? dy_ff : oy_ff;
      om_in = load ? (sat_ff ? {MAG_W{1'b1}} : root_ff) : om_ff;
      oeor_in = load ? eor_ff : oeor_ff;
      oeof_in = load ? eof_ff : oeof_ff;
      ov_in = load ? 1'b1 : (rsp_tready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      val_ff <= val_in;
      sat_ff <= sat_in;
      root_ff <= root_in;
      step_ff <= step_in;
      eor_ff <= eor_in;
      eof_ff <= eof_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      om_ff <= om_in;
      oeor_ff <= oeor_in;
      oeof_ff <= oeof_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, om_ff, oy_ff, ox_ff};
   assign rsp_tlast  = oeor_ff;
   assign rsp_tuser  = oeof_ff;

   `SGC_ASSERT_IMP(a_root_not_above, (state_ff == G_DONE) && !sat_ff,
                   (32'(root_ff) * 32'(root_ff)) <= 32'(val_ff))
   `SGC_ASSERT_NXT(a_start_taken, (state_ff == G_IDLE) && start, state_ff == G_SQR)

endmodule

>>> rtl/sobel_gradient_clamped.sv
// ---------------------------------------------------------------------------
// sobel_gradient_clamped
// Streaming 3x3 Sobel edge detector with clamp-to-border edges.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order on the req_ channel with tuser low; a beat
// with tuser high is a flush that drains one result of the last row once a
// frame has ended. Results for a row come out while the next row streams in.
// A pixel beat occupies the controller for a line store read, write-back and
// hand-off to the magnitude unit; a flush beat for three line store reads,
// assembly and hand-off. Roots are found one bit per cycle, and the magnitude
// unit takes a job once its last result sits in its output register. A row's
// last pixel gives two results after row 0 if width exceeds one. Line stores
// need no clearing after reset. Configuration writes are taken at any time.
`include "assert_macros.svh"

module sobel_gradient_clamped (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_value [7:0]
   input  logic [sgc_pkg::PIX_W-1:0]         req_tdata,
   // opcode [0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // grad_x [10:0], grad_y [21:11], magnitude [29:22], zero [31:30]
   output logic [sgc_pkg::RSP_DAT_W-1:0]     rsp_tdata,
   // end_of_row
   output logic                              rsp_tlast,
   // end_of_frame [0]
   output logic [0:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sgc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgc_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import sgc_pkg::*;

   ctl_state_type state_ff, state_in;
   logic [FW_W-1:0]   rw_ff, rw_in;
   logic [ROW_W-1:0]  rh_ff, rh_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WCNT_W-1:0] pend_ff, pend_in, dw_ff, dw_in;
   logic              single_ff, single_in;
   col_type           wl_ff, wl_in, wc_ff, wc_in, wr_ff, wr_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   job_type           ja_ff, ja_in, jb_ff, jb_in;
   logic              ha_ff, ha_in, hb_ff, hb_in;
   logic [ADDR_W-1:0] k_ff, k_in, jr_ff, jr_in;
   logic              fl_last_ff, fl_last_in;

   logic              accept, acc_pix, acc_flush, drain_ok;
   logic [WCNT_W-1:0] eff_w, k_c;
   logic [ROW_W-1:0]  eff_h;
   logic [ADDR_W-1:0] jl_c, jr_c;
   logic              last_col, frame_end;
   col_type           rd_col, pix_col;

   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIX_W-1:0]  up_q, mid_q;
   logic              g_start, g_ready;
   job_type           g_job;

   assign accept    = req_tvalid && req_tready;
   assign acc_pix   = accept && (req_tuser[0] == OP_PIXEL);
   assign acc_flush = accept && (req_tuser[0] == OP_FLUSH);
   assign drain_ok  = (pend_ff != '0) && (pend_ff <= dw_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      if (rw_ff == '0) eff_w = WCNT_W'(1);
      else if (32'(rw_ff) > MAX_WIDTH) eff_w = WCNT_W'(MAX_WIDTH);
      else eff_w = WCNT_W'(rw_ff);
      eff_h = (rh_ff == '0) ? ROW_W'(1) : rh_ff;
      k_c  = dw_ff - pend_ff;
      jl_c = (k_c == '0) ? '0 : ADDR_W'(k_c - WCNT_W'(1));
      jr_c = ((k_c + WCNT_W'(1)) >= dw_ff) ? ADDR_W'(dw_ff - WCNT_W'(1))
                                          : ADDR_W'(k_c + WCNT_W'(1));
      last_col  = (WCNT_W'(col_ff) + WCNT_W'(1)) >= eff_w;
      frame_end = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
      rd_col.top = single_ff ? mid_q : up_q;
      rd_col.mid = mid_q;
      rd_col.bot = mid_q;
      pix_col.top = (row_ff <= ROW_W'(1)) ? mid_q : up_q;
      pix_col.mid = mid_q;
      pix_col.bot = pix_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_pix) state_in = ST_PIX;
            else if (acc_flush && drain_ok) state_in = ST_FL0;
         end
         ST_PIX:   state_in = ST_ISSUE;
         ST_FL0:   state_in = ST_FL1;
         ST_FL1:   state_in = ST_FL2;
         ST_FL2:   state_in = ST_ISSUE;
         ST_ISSUE: if (!ha_ff && !hb_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      ram_en = 1'b0;
      ram_we = 1'b0;
      ram_addr = col_ff;
      g_start = 1'b0;
      g_job = ha_ff ? ja_ff : jb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_en = acc_pix || (acc_flush && drain_ok);
            ram_addr = acc_pix ? col_ff : jl_c;
         end
         ST_PIX: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
         end
         ST_FL0: begin
            ram_en = 1'b1;
            ram_addr = k_ff;
         end
         ST_FL1: begin
            ram_en = 1'b1;
            ram_addr = jr_ff;
         end
         ST_FL2: ram_en = 1'b0;
         ST_ISSUE: g_start = ha_ff || hb_ff;
         default: ram_en = 1'b0;
      endcase
   end

   always_comb begin
      rw_in = rw_ff;
      rh_in = rh_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  rw_in = csr_wdata[FW_W-1:0];
            REG_FRAME_HEIGHT: rh_in = csr_wdata[ROW_W-1:0];
            default:          rw_in = rw_ff;
         endcase
      end
      col_in = col_ff;
      row_in = row_ff;
      pend_in = pend_ff;
      dw_in = dw_ff;
      single_in = single_ff;
      wl_in = wl_ff;
      wc_in = wc_ff;
      wr_in = wr_ff;
      pix_in = pix_ff;
      ja_in = ja_ff;
      jb_in = jb_ff;
      ha_in = ha_ff;
      hb_in = hb_ff;
      k_in = k_ff;
      jr_in = jr_ff;
      fl_last_in = fl_last_ff;
      if (acc_pix) begin
         pix_in = req_tdata;
         pend_in = '0;
      end
      if (acc_flush && drain_ok) begin
         k_in = ADDR_W'(k_c);
         jr_in = jr_c;
         pend_in = pend_ff - WCNT_W'(1);
         fl_last_in = (pend_ff == WCNT_W'(1));
      end
      unique case (state_ff)
         ST_PIX: begin
            if (col_ff == '0) begin
               wl_in = pix_col;
               wc_in = pix_col;
               wr_in = pix_col;
            end else begin
               wl_in = wc_ff;
               wc_in = wr_ff;
               wr_in = pix_col;
            end
            ja_in = '{left: wl_in, center: wc_in, right: wr_in, eor: 1'b0, eof: 1'b0};
            jb_in = '{left: wc_in, center: wr_in, right: wr_in, eor: 1'b1, eof: 1'b0};
            ha_in = (row_ff != '0) && (col_ff != '0);
            hb_in = (row_ff != '0) && last_col;
            if (last_col) begin
               col_in = '0;
               if (frame_end) begin
                  row_in = '0;
                  pend_in = eff_w;
                  dw_in = eff_w;
                  single_in = (row_ff == '0);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end
         ST_FL0: ja_in.left = rd_col;
         ST_FL1: ja_in.center = rd_col;
         ST_FL2: begin
            ja_in.right = rd_col;
            ja_in.eor = fl_last_ff;
            ja_in.eof = fl_last_ff;
            ha_in = 1'b1;
            hb_in = 1'b0;
         end
         ST_ISSUE: begin
            if (g_start && g_ready) begin
               if (ha_ff) ha_in = 1'b0;
               else hb_in = 1'b0;
            end
         end
         default: ha_in = ha_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rw_ff     <= FW_W'(640);
         rh_ff     <= ROW_W'(480);
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
         dw_ff     <= '0;
         single_ff <= 1'b0;
         ha_ff     <= 1'b0;
         hb_ff     <= 1'b0;
         wl_ff     <= '0;
         wc_ff     <= '0;
         wr_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         rw_ff     <= rw_in;
         rh_ff     <= rh_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
         dw_ff     <= dw_in;
         single_ff <= single_in;
         ha_ff     <= ha_in;
         hb_ff     <= hb_in;
         wl_ff     <= wl_in;
         wc_ff     <= wc_in;
         wr_ff     <= wr_in;
      end
      pix_ff     <= pix_in;
      ja_ff      <= ja_in;
      jb_ff      <= jb_in;
      k_ff       <= k_in;
      jr_ff      <= jr_in;
      fl_last_ff <= fl_last_in;
   end

   sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (mid_q),
      .rdata (up_q)
   );

   sgc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (pix_ff),
      .rdata (mid_q)
   );

   sgc_grad u_grad (
      .clock      (clock),
      .reset      (reset),
      .start      (g_start),
      .job        (g_job),
      .ready      (g_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `SGC_ASSERT_IMP(a_pix_from_beat, state_ff == ST_PIX, $past(acc_pix))
   `SGC_ASSERT_IMP(a_pend_in_range, 1'b1, pend_ff <= dw_ff)

endmodule

>>> dv/sobel_gradient_clamped_test.sv
// ---------------------------------------------------------------------------
// sobel_gradient_clamped_test
// Self-checking testbench of the clamped Sobel gradient block.
// ---------------------------------------------------------------------------
// Pixel and flush beats go in through the request stream. A behavioral
// predictor of the line stores, the window and the drain computes every
// gradient result, which is then compared field by field with the response
// stream. Directed frames cover the border cases and zeroed frame registers.
// Random frames follow, with both sides stalling at random.
module sobel_gradient_clamped_test;
   import sgc_pkg::*;

   typedef struct {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic [MAG_W-1:0]         mag;
      logic                     eor;
      logic                     eof;
   } grad_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0]  rsp_tdata;
   logic                  rsp_tlast;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;

   grad_type   grad_queue[$];
   int         errors = 0;
   int         burst_left = 0;
   int         random_items = 0;

   logic [PIX_W-1:0] line_top[MAX_WIDTH];
   logic [PIX_W-1:0] line_mid[MAX_WIDTH];
   col_type    win_l, win_c, win_r;
   int         col_cnt, row_cnt, pending, drain_w;
   bit         drain_single;
   int         width_reg, height_reg;

   sobel_gradient_clamped u_top (.*);

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int isqrt_sat(int v);
      int root;
      root = 0;
      if (v >= 65536) return 255;
      for (int b = 128; b != 0; b = b >> 1)
         if ((root | b) * (root | b) <= v) root = root | b;
      return root;
   endfunction

   function automatic grad_type gradient(col_type l, col_type c, col_type r, bit eor, bit eof);
      grad_type g;
      int dx, dy;
      dx = (r.top + 2 * r.mid + r.bot) - (l.top + 2 * l.mid + l.bot);
      dy = (l.bot + 2 * c.bot + r.bot) - (l.top + 2 * c.top + r.top);
      g.gx = GRAD_W'(dx);
      g.gy = GRAD_W'(dy);
      g.mag = MAG_W'(isqrt_sat(dx * dx + dy * dy));
      g.eor = eor;
      g.eof = eof;
      return g;
   endfunction

   function automatic col_type drain_col(int j);
      col_type c;
      c.mid = line_mid[j];
      c.bot = line_mid[j];
      c.top = drain_single ? line_mid[j] : line_top[j];
      return c;
   endfunction

   task automatic predict(logic op, logic [PIX_W-1:0] pix);
      int w, h, k, jl, jr, idx;
      bit last_col;
      col_type col;
      w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = height_reg < 1 ? 1 : height_reg;
      if (op == OP_FLUSH) begin
         if (pending == 0 || pending > drain_w) return;
         k = drain_w - pending;
         jl = k == 0 ? 0 : k - 1;
         jr = k + 1 >= drain_w ? drain_w - 1 : k + 1;
         pending--;
         grad_queue.push_back(gradient(drain_col(jl), drain_col(k), drain_col(jr),
                                       pending == 0, pending == 0));
         return;
      end
      idx = col_cnt >= MAX_WIDTH ? MAX_WIDTH - 1 : col_cnt;
      last_col = col_cnt + 1 >= w;
      pending = 0;
      col.mid = line_mid[idx];
      col.top = row_cnt <= 1 ? col.mid : line_top[idx];
      col.bot = pix;
      line_top[idx] = line_mid[idx];
      line_mid[idx] = pix;
      if (col_cnt == 0) begin
         win_l = col;
         win_c = col;
         win_r = col;
      end else begin
         win_l = win_c;
         win_c = win_r;
         win_r = col;
      end
      if (row_cnt >= 1 && col_cnt >= 1)
         grad_queue.push_back(gradient(win_l, win_c, win_r, 1'b0, 1'b0));
      if (row_cnt >= 1 && last_col)
         grad_queue.push_back(gradient(win_c, win_r, win_r, 1'b1, 1'b0));
      if (last_col) begin
         col_cnt = 0;
         if (row_cnt + 1 >= h) begin
            drain_single = (row_cnt == 0);
            row_cnt = 0;
            pending = w;
            drain_w = w;
         end else begin
            row_cnt++;
         end
      end else begin
         col_cnt++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   task automatic send_beat(logic op, logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      predict(op, pix);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (grad_queue.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_FRAME_WIDTH) width_reg = val & 12'h7FF;
      else height_reg = val;
   endtask

   task automatic set_frame(int w, int h);
      wait_idle();
      write_reg(REG_FRAME_WIDTH, CSR_DAT_W'(w));
      write_reg(REG_FRAME_HEIGHT, CSR_DAT_W'(h));
      csr_valid <= 1'b0;
   endtask

   task automatic send_frame(int w, int h, int mode);
      for (int i = 0; i < w * h; i++)
         case (mode)
            0: send_beat(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
            1: send_beat(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
            default: send_beat(OP_PIXEL, (i < w * h / 2) ? 8'h00 : 8'hFF);
         endcase
   endtask

   task automatic send_flushes(int n);
      repeat (n) send_beat(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic test_small_frames();
      send_flushes(2);
      set_frame(3, 3);
      send_frame(3, 3, 1);
      send_flushes(4);
      send_frame(3, 3, 2);
      send_flushes(1);
      send_frame(3, 3, 0);
      send_flushes(3);
   endtask

   task automatic test_border_shapes();
      set_frame(4, 1);
      send_frame(4, 1, 1);
      send_flushes(4);
      set_frame(1, 2);
      send_frame(1, 2, 2);
      send_flushes(1);
      set_frame(0, 0);
      send_frame(1, 1, 0);
      send_flushes(2);
   endtask

   task automatic test_register_extremes();
      set_frame(48, 2);
      send_frame(48, 2, 2);
      send_flushes(48);
      set_frame(1, 40);
      send_frame(1, 40, 0);
      send_flushes(1);
   endtask

   task automatic test_random_frames();
      int w, h, nf;
      while (random_items < 180) begin
         w = $urandom_range(0, 7) == 0 ? $urandom_range(17, 32) : $urandom_range(1, 16);
         h = $urandom_range(1, 4);
         set_frame(w, h);
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0) send_flushes(1);
            send_frame(w, h, 0);
            nf = $urandom_range(0, 3) == 0 ? $urandom_range(0, w + 2) : w;
            send_flushes(nf);
            random_items += w * h + nf;
         end
      end
   endtask

   // Receiver: checks every beat and stalls according to a stall mode drawn at random.
   int stall_mode = 0, stall_cnt = 0;
   always @(posedge clock) begin
      grad_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grad_queue.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = grad_queue.pop_front();
            if (rsp_tdata[10:0] !== e.gx) begin
               $display("%0t: grad_x expected %0d actual %0d", $time, e.gx,
                        $signed(rsp_tdata[10:0]));
               errors++;
            end
            if (rsp_tdata[21:11] !== e.gy) begin
               $display("%0t: grad_y expected %0d actual %0d", $time, e.gy,
                        $signed(rsp_tdata[21:11]));
               errors++;
            end
            if (rsp_tdata[29:22] !== e.mag) begin
               $display("%0t: magnitude expected %0d actual %0d", $time, e.mag,
                        rsp_tdata[29:22]);
               errors++;
            end
            if (rsp_tlast !== e.eor) begin
               $display("%0t: end_of_row expected %0b actual %0b", $time, e.eor, rsp_tlast);
               errors++;
            end
            if (rsp_tuser[0] !== e.eof) begin
               $display("%0t: end_of_frame expected %0b actual %0b", $time, e.eof,
                        rsp_tuser[0]);
               errors++;
            end
         end
      end
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= $urandom_range(0, 3) == 0;
      endcase
   end

   initial begin
      width_reg = 640;
      height_reg = 480;
      col_cnt = 0;
      row_cnt = 0;
      pending = 0;
      drain_w = 0;
      drain_single = 0;
      win_l = '0;
      win_c = '0;
      win_r = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_small_frames();
      test_border_shapes();
      test_register_extremes();
      test_random_frames();
      wait_idle();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
